[hw/rtl/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/lsps_pkg.sv]
package lsps_pkg;

    localparam int FULL_SCALE    = 4095;
    localparam int POS_PITCH     = 1000;
    localparam int PD_FLOOR      = -4000;
    localparam int BLACK_DEFAULT = 1100;
    localparam int DUTY_MAX      = 255;

    localparam logic [2:0] REG_CALIBRATE = 3'd0;
    localparam logic [2:0] REG_PROP_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] REG_STEER_DIV = 3'd3;
    localparam logic [2:0] REG_BASE_SPEED = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SENSE,
        ST_NDIV,
        ST_NSTORE,
        ST_ACCUM,
        ST_PDIV,
        ST_PD,
        ST_SDIV,
        ST_MIX,
        ST_CAL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic sign;
    } div_ctl_t;

endpackage

[hw/rtl/lsps_div.sv]
module lsps_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  lsps_pkg::div_ctl_t ctl,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [W:0]    trial;
    logic [W:0]    shifted;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        shifted  = {rem_reg[W-1:0], quo_reg[W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        if (ctl.start)
        begin
            neg_next = ctl.sign & dividend[W-1];
            quo_next = (ctl.sign & dividend[W-1]) ? (~dividend + 1'b1) : dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(W);
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            neg_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            neg_reg <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = ctl.start || (cnt_reg != '0);
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

[hw/rtl/line_sensor_pd_steering.sv]
// Line sensor PD steering.
// s_axis: one request carries eight raw 12-bit samples, raw_s0 lowest in
// tdata. m_axis: one result per request with bitmap, position, no_line flag,
// steering value and two motor duties with reverse bits.
// cfg: register index and data, to be written by the user only while idle;
// the block itself does not enforce this. Run mode: each sensor is
// normalized in turn (sense, divider start and wait), then the sums
// accumulate, the centroid and steering divisions run and the result is
// mixed and registered. Calibrate mode skips the normalizations and
// updates the levels at the end. One shared 32-step restoring divider
// serves all divisions in turn. The next request is taken only after the
// result has left the output register; s_axis_tready is low until then.
// Reset puts the registers at their documented defaults, black levels at
// 1100 and white, threshold and normalized levels at zero.
// When m_axis_tready is low the result holds in the output register and no
// new request is taken.
// Position holds its previous value when all normalized values are zero.
// Steering is zero for PD sums below -4000.
module line_sensor_pd_steering #(
    parameter int NORM_SCALE = 1000
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // raw_s0 .. raw_s7, 12 bits each
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // line_bitmap[7:0], line_position[20:8], no_line[21], steering[40:22],
    // left_duty[48:41], left_reverse[49], right_duty[57:50], right_reverse[58]
    output logic [63:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    localparam int N = 8;
    localparam int NW = $clog2(NORM_SCALE + 1);

    lsps_pkg::state_t state_reg, state_next;

    logic        cal_reg;
    logic [3:0]  kp_reg, kd_reg;
    logic [7:0]  sdiv_reg, speed_reg;
    logic [11:0] black_reg [N];
    logic [11:0] white_reg [N];
    logic [11:0] thr_reg [N];
    logic [NW-1:0] norm_reg [N];
    logic signed [12:0] prev_reg;

    logic [11:0] inv_reg [N];
    logic [2:0]  idx_reg, idx_next;
    logic [7:0]  bmp_reg;
    logic [31:0] wsum_reg;
    logic [15:0] nsum_reg;
    logic signed [12:0] pos_reg;
    logic signed [18:0] steer_reg;
    logic        noline_reg;
    logic [63:0] out_reg;
    logic        ovalid_reg;

    lsps_pkg::div_ctl_t dctl;
    logic [31:0] d_num, d_den, d_quo;
    logic        d_busy;

    lsps_div #(.W(32)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(d_num),
        .divisor(d_den), .busy(d_busy), .quotient(d_quo)
    );

    logic [11:0] cb, cw, cv, cinv;
    logic [11:0] craise;
    logic [11:0] bc;
    logic [11:0] nb, nwh;
    logic signed [31:0] pd_calc;
    logic signed [31:0] spd, lft, rgt;
    logic signed [31:0] dl, dr;
    logic [7:0] lduty, rduty;

    assign cb     = black_reg[idx_reg];
    assign cw     = white_reg[idx_reg];
    assign cinv   = inv_reg[idx_reg];
    assign craise = (cinv < cb) ? cb : cinv;
    assign cv     = (craise > cw) ? cw : craise;
    assign bc     = (cb == 12'd0) ? 12'(lsps_pkg::BLACK_DEFAULT) : cb;
    assign nb     = (cinv < bc) ? cinv : bc;
    assign nwh    = (cinv > cw) ? cinv : cw;

    assign pd_calc = 32'(signed'({1'b0, kp_reg})) * 32'(pos_reg)
                   - 32'(signed'({1'b0, kd_reg})) * (32'(prev_reg) - 32'(pos_reg));

    always_comb
    begin
        spd = 32'(speed_reg);
        if (spd + 32'(steer_reg) > 32'(lsps_pkg::DUTY_MAX))
            spd = 32'(lsps_pkg::DUTY_MAX) - 32'(steer_reg);
        if (spd - 32'(steer_reg) > 32'(lsps_pkg::DUTY_MAX))
            spd = 32'(lsps_pkg::DUTY_MAX) + 32'(steer_reg);
        lft = spd + 32'(steer_reg);
        rgt = spd - 32'(steer_reg);
        dl = lft[31] ? (32'(lsps_pkg::DUTY_MAX) + lft) : lft;
        dr = rgt[31] ? (32'(lsps_pkg::DUTY_MAX) + rgt) : rgt;
        lduty = dl[31] ? 8'd0 : ((dl > 32'sd255) ? 8'd255 : dl[7:0]);
        rduty = dr[31] ? 8'd0 : ((dr > 32'sd255) ? 8'd255 : dr[7:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsps_pkg::ST_IDLE:   if (s_axis_tvalid && !ovalid_reg) state_next = lsps_pkg::ST_SENSE;
            lsps_pkg::ST_SENSE:
                if (cal_reg)
                    state_next = (idx_reg == 3'(N - 1)) ? lsps_pkg::ST_ACCUM : lsps_pkg::ST_SENSE;
                else
                    state_next = lsps_pkg::ST_NDIV;
            lsps_pkg::ST_NDIV:   state_next = lsps_pkg::ST_NSTORE;
            lsps_pkg::ST_NSTORE:
                if (!d_busy)
                    state_next = (idx_reg == 3'(N - 1)) ? lsps_pkg::ST_ACCUM : lsps_pkg::ST_SENSE;
            lsps_pkg::ST_ACCUM:
                if (idx_reg == 3'(N - 1)) state_next = lsps_pkg::ST_PDIV;
            lsps_pkg::ST_PDIV:   if (!d_busy) state_next = lsps_pkg::ST_PD;
            lsps_pkg::ST_PD:     state_next = lsps_pkg::ST_SDIV;
            lsps_pkg::ST_SDIV:   if (!d_busy) state_next = lsps_pkg::ST_MIX;
            lsps_pkg::ST_MIX:    state_next = cal_reg ? lsps_pkg::ST_CAL : lsps_pkg::ST_OUT;
            lsps_pkg::ST_CAL:
                if (idx_reg == 3'(N - 1)) state_next = lsps_pkg::ST_OUT;
            lsps_pkg::ST_OUT:    state_next = lsps_pkg::ST_IDLE;
            default:             state_next = lsps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        dctl  = '0;
        d_num = '0;
        d_den = 32'd1;
        idx_next = idx_reg;
        case (state_reg)
            lsps_pkg::ST_IDLE:   idx_next = '0;
            lsps_pkg::ST_SENSE:  if (cal_reg) idx_next = idx_reg + 1'b1;
            lsps_pkg::ST_NDIV:
            begin
                dctl.start = 1'b1;
                d_num = 32'(cv - cb) * 32'(NORM_SCALE);
                d_den = (cw > cb) ? 32'(cw - cb) : 32'd1;
            end
            lsps_pkg::ST_NSTORE: if (!d_busy) idx_next = idx_reg + 1'b1;
            lsps_pkg::ST_ACCUM:  idx_next = idx_reg + 1'b1;
            lsps_pkg::ST_PDIV:
            begin
                d_num = wsum_reg;
                d_den = (nsum_reg == '0) ? 32'd1 : 32'(nsum_reg);
            end
            lsps_pkg::ST_PD:
            begin
                dctl.start = 1'b1;
                dctl.sign  = 1'b1;
                d_num = (pd_calc < 32'(lsps_pkg::PD_FLOOR)) ? 32'd0 : pd_calc;
                d_den = (sdiv_reg == 8'd0) ? 32'd1 : 32'(sdiv_reg);
            end
            lsps_pkg::ST_CAL:    idx_next = idx_reg + 1'b1;
            default:             idx_next = idx_reg;
        endcase
        if (state_reg == lsps_pkg::ST_ACCUM && idx_reg == 3'(N - 1))
        begin
            dctl.start = 1'b1;
            d_num = wsum_reg + 32'(norm_reg[idx_reg]) * 32'(N - 1) * 32'(lsps_pkg::POS_PITCH);
            d_den = ((nsum_reg + 16'(norm_reg[idx_reg])) == '0) ? 32'd1
                  : 32'(nsum_reg + 16'(norm_reg[idx_reg]));
        end
        if (state_reg == lsps_pkg::ST_PD) dctl.start = 1'b1;
    end

    assign s_axis_tready = (state_reg == lsps_pkg::ST_IDLE) && !ovalid_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lsps_pkg::ST_IDLE;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
            cal_reg    <= 1'b1;
            kp_reg     <= 4'd1;
            kd_reg     <= 4'd3;
            sdiv_reg   <= 8'd20;
            speed_reg  <= 8'd0;
            prev_reg   <= '0;
            for (int j = 0; j < N; j++)
            begin
                black_reg[j] <= 12'(lsps_pkg::BLACK_DEFAULT);
                white_reg[j] <= '0;
                thr_reg[j]   <= '0;
                norm_reg[j]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    lsps_pkg::REG_CALIBRATE:  cal_reg   <= cfg_data[0];
                    lsps_pkg::REG_PROP_GAIN:  kp_reg    <= cfg_data[3:0];
                    lsps_pkg::REG_DERIV_GAIN: kd_reg    <= cfg_data[3:0];
                    lsps_pkg::REG_STEER_DIV:  sdiv_reg  <= cfg_data;
                    lsps_pkg::REG_BASE_SPEED: speed_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == lsps_pkg::ST_NSTORE && !d_busy)
                norm_reg[idx_reg] <= (cw > cb) ? NW'(d_quo) : '0;
            if (state_reg == lsps_pkg::ST_PD)
                prev_reg <= pos_reg;
            if (state_reg == lsps_pkg::ST_CAL)
            begin
                black_reg[idx_reg] <= nb;
                white_reg[idx_reg] <= nwh;
                thr_reg[idx_reg]   <= 12'(({1'b0, nb} + {1'b0, nwh}) >> 1);
            end
            if (state_reg == lsps_pkg::ST_OUT)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            lsps_pkg::ST_IDLE:
            begin
                for (int j = 0; j < N; j++)
                    inv_reg[j] <= 12'(lsps_pkg::FULL_SCALE) - s_axis_tdata[12*j +: 12];
                bmp_reg  <= '0;
                wsum_reg <= '0;
                nsum_reg <= '0;
            end
            lsps_pkg::ST_SENSE:
                bmp_reg <= {bmp_reg[6:0], ((cal_reg ? cinv : cv) > thr_reg[idx_reg])};
            lsps_pkg::ST_ACCUM:
            begin
                wsum_reg <= wsum_reg + 32'(norm_reg[idx_reg]) * 32'(idx_reg)
                            * 32'(lsps_pkg::POS_PITCH);
                nsum_reg <= nsum_reg + 16'(norm_reg[idx_reg]);
                noline_reg <= ((nsum_reg + 16'(norm_reg[idx_reg])) == '0);
            end
            lsps_pkg::ST_PDIV:
                if (!d_busy)
                    pos_reg <= noline_reg ? prev_reg
                             : 13'(d_quo - 32'((N - 1) * lsps_pkg::POS_PITCH / 2));
            lsps_pkg::ST_SDIV:
                if (!d_busy) steer_reg <= 19'(d_quo);
            lsps_pkg::ST_MIX:
                out_reg <= {5'd0, rgt[31], rduty, lft[31], lduty, steer_reg,
                            noline_reg, pos_reg, bmp_reg};
            default: ;
        endcase
    end

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `ASSERT_IMPL(a_no_accept_busy, state_reg != lsps_pkg::ST_IDLE, !s_axis_tready, "busy accept")
    `ASSERT_IMPL(a_div_idle, state_reg == lsps_pkg::ST_IDLE, !d_busy, "divider busy at idle")

endmodule
